// ===== hdl/gap_pkg.sv =====
// Shared types, constants and a helper function for the grid path search block.
package gap_pkg;

  // Grid geometry and field widths.
  localparam int MAP_SIDE   = 64;
  localparam int COORD_W    = 6;
  localparam int CELL_W     = 12;
  localparam int CELL_COUNT = 4096;
  localparam int COST_W     = 12;
  localparam int GUESS_W    = 11;
  localparam int CNT_W      = 13;
  localparam int SUM_W      = 13;
  localparam int DIM_W      = 7;
  localparam int MASK_W     = 8;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Command opcodes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DIR_MASK    = 3'd0;
  localparam logic [2:0] REG_OPEN_LIMIT  = 3'd1;
  localparam logic [2:0] REG_CLOSE_LIMIT = 3'd2;
  localparam logic [2:0] REG_MAP_WIDTH   = 3'd3;
  localparam logic [2:0] REG_MAP_HEIGHT  = 3'd4;

  // Register reset values.
  localparam logic [MASK_W-1:0] RST_DIR_MASK    = 8'hFF;
  localparam logic [CNT_W-1:0]  RST_OPEN_LIMIT  = 13'd4096;
  localparam logic [CNT_W-1:0]  RST_CLOSE_LIMIT = 13'd204;
  localparam logic [DIM_W-1:0]  RST_MAP_DIM     = 7'd64;

  localparam logic [COST_W-1:0] COST_UNREACHED = '1;

  // Move offsets: north first, then clockwise.
  localparam logic signed [1:0] MOVE_DX [8] =
    '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] MOVE_DY [8] =
    '{-2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1};

  // A list link or parent pointer: valid flag plus cell index.
  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] idx;
  } link_t;

  // One cell's search record as held in the node memory.
  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [1:0]         flags;   // bit0 open, bit1 closed
    logic [GUESS_W-1:0] guess;
    link_t              parent;
    link_t              next;
    link_t              prev;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  localparam node_t NODE_CLEAR = '{cost: COST_UNREACHED, flags: 2'b00, guess: '0,
                                   parent: '0, next: '0, prev: '0};

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic               passable;
    logic [COST_W-1:0]  step_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COORD_W-1:0] reach_x;
    logic [COORD_W-1:0] reach_y;
    logic [COST_W-1:0]  path_cost;
    logic [COORD_W-1:0] step_x;
    logic [COORD_W-1:0] step_y;
  } res_t;

  typedef struct packed {
    logic [MASK_W-1:0] dir_mask;
    logic [CNT_W-1:0]  open_limit;
    logic [CNT_W-1:0]  close_limit;
    logic [DIM_W-1:0]  map_width;
    logic [DIM_W-1:0]  map_height;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    node_t             data;
  } node_wr_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic              data;
  } pass_wr_t;

  // Nine times the Manhattan distance between two cells.
  function automatic logic [GUESS_W-1:0] estimate(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] gx,
                                                  input logic [COORD_W-1:0] gy);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W:0]   s;
    dx = (x >= gx) ? (x - gx) : (gx - x);
    dy = (y >= gy) ? (y - gy) : (gy - y);
    s  = {1'b0, dx} + {1'b0, dy};
    return {1'b0, s, 3'b000} + {4'b0000, s};
  endfunction

endpackage

// ===== hdl/gap_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module gap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gap_search.sv =====
// Search sequencer: runs commands against the node and passability memories.
module gap_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  gap_pkg::cmd_t      cmd,
  output logic               cmd_ready,
  input  gap_pkg::cfg_t      cfg,
  output logic               res_valid,
  output gap_pkg::res_t      res,
  input  logic               res_ready,
  output gap_pkg::node_wr_t  node_wr,
  output logic [11:0]        node_raddr,
  input  gap_pkg::node_t     node_rdata,
  output gap_pkg::pass_wr_t  pass_wr,
  output logic [11:0]        pass_raddr,
  input  logic               pass_rdata
);
  import gap_pkg::*;

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_CLEAR, S_ROOT, S_POP, S_POP_D, S_POP_P1, S_POP_P2, S_GOAL,
    S_DIR, S_NB, S_UL1, S_UL2, S_INS, S_WALK, S_WALK_D, S_LINK, S_LINK_B,
    S_LINK_P, S_NEXTDIR, S_AFTER, S_CPOP, S_CPOP_P, S_LIM, S_FIN, S_FIN_D,
    S_RD_BEST, S_TRACE, S_TRACE_D, S_PATCH_RD, S_PATCH_WR, S_DONE
  } state_t;

  state_t              state_r, state_nxt, ret_r, ret_nxt;
  logic [CELL_W-1:0]   clr_r, clr_nxt;
  logic [COORD_W-1:0]  goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [CELL_W-1:0]   start_r, start_nxt;
  logic [COST_W-1:0]   si_r, si_nxt;
  link_t               open_head_r, open_head_nxt, close_head_r, close_head_nxt;
  logic [CNT_W-1:0]    open_cnt_r, open_cnt_nxt, close_cnt_r, close_cnt_nxt;
  logic [CELL_W-1:0]   best_r, best_nxt;
  logic [GUESS_W-1:0]  min_guess_r, min_guess_nxt;
  logic                have_path_r, have_path_nxt;
  logic [CELL_W-1:0]   cur_r, cur_nxt;
  logic [COST_W-1:0]   cur_cost_r, cur_cost_nxt;
  logic [2:0]          dir_r, dir_nxt;
  logic                all_fail_r, all_fail_nxt;
  logic [CELL_W-1:0]   nb_r, nb_nxt;
  node_t               nb_rec_r, nb_rec_nxt;
  link_t               tmp_a_r, tmp_a_nxt, tmp_b_r, tmp_b_nxt;
  logic                ul_close_r, ul_close_nxt;
  link_t               walk_p_r, walk_p_nxt, walk_b_r, walk_b_nxt;
  logic [SUM_W-1:0]    f_r, f_nxt;
  logic [CELL_W-1:0]   patch_addr_r, patch_addr_nxt;
  logic                patch_next_r, patch_next_nxt;
  link_t               patch_val_r, patch_val_nxt;
  res_t                res_r, res_nxt;

  // Neighbor address arithmetic for the direction under test.
  logic [DIM_W-1:0]    map_w_eff, map_h_eff;
  logic [7:0]          nx, ny;
  logic                nb_in_map;
  logic [COST_W:0]     cand;
  logic [SUM_W-1:0]    rd_sum;
  node_t               rec_w;
  link_t               cur_link, nb_link;

  assign map_w_eff = (cfg.map_width > DIM_W'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : cfg.map_width;
  assign map_h_eff = (cfg.map_height > DIM_W'(MAP_SIDE)) ? DIM_W'(MAP_SIDE) : cfg.map_height;
  assign nx = {2'b00, cur_r[COORD_W-1:0]} + {{6{MOVE_DX[dir_r][1]}}, MOVE_DX[dir_r]};
  assign ny = {2'b00, cur_r[CELL_W-1:COORD_W]} + {{6{MOVE_DY[dir_r][1]}}, MOVE_DY[dir_r]};
  assign nb_in_map = !nx[7] && !ny[7] && (nx < {1'b0, map_w_eff}) && (ny < {1'b0, map_h_eff});
  assign cand   = {1'b0, cur_cost_r} + {{COST_W{1'b0}}, 1'b1};
  assign rd_sum = {1'b0, node_rdata.cost} + {2'b00, node_rdata.guess};
  assign cur_link = '{valid: 1'b1, idx: cur_r};
  assign nb_link  = '{valid: 1'b1, idx: nb_r};

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Next-state and memory control.
  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;       clr_nxt = clr_r;
    goal_x_nxt = goal_x_r; goal_y_nxt = goal_y_r; start_nxt = start_r;
    si_nxt = si_r;         open_head_nxt = open_head_r;
    close_head_nxt = close_head_r;               open_cnt_nxt = open_cnt_r;
    close_cnt_nxt = close_cnt_r;                 best_nxt = best_r;
    min_guess_nxt = min_guess_r;                 have_path_nxt = have_path_r;
    cur_nxt = cur_r;       cur_cost_nxt = cur_cost_r;                dir_nxt = dir_r;
    all_fail_nxt = all_fail_r;                   nb_nxt = nb_r;
    nb_rec_nxt = nb_rec_r; tmp_a_nxt = tmp_a_r;  tmp_b_nxt = tmp_b_r;
    ul_close_nxt = ul_close_r;                   walk_p_nxt = walk_p_r;
    walk_b_nxt = walk_b_r; f_nxt = f_r;          patch_addr_nxt = patch_addr_r;
    patch_next_nxt = patch_next_r;               patch_val_nxt = patch_val_r;
    res_nxt = res_r;
    rec_w = node_rdata;
    node_wr = '0;
    node_raddr = '0;
    pass_wr = '0;
    pass_raddr = '0;

    unique case (state_r)
      // Sweep after reset: every cell blocked and unreached.
      S_BOOT: begin
        node_wr = '{we: 1'b1, addr: clr_r, data: NODE_CLEAR};
        pass_wr = '{we: 1'b1, addr: clr_r, data: 1'b0};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          res_nxt = '0;
          case (cmd.opcode)
            OP_WRITE: begin
              pass_wr = '{we: 1'b1, addr: {cmd.cell_y, cmd.cell_x}, data: cmd.passable};
              state_nxt = S_DONE;
            end
            OP_FIND: begin
              start_nxt  = {cmd.cell_y, cmd.cell_x};
              goal_x_nxt = cmd.goal_x;
              goal_y_nxt = cmd.goal_y;
              clr_nxt    = '0;
              state_nxt  = S_CLEAR;
            end
            OP_READ: begin
              si_nxt = cmd.step_index;
              if (have_path_r) begin
                node_raddr = best_r;
                state_nxt  = S_RD_BEST;
              end else begin
                res_nxt.status = ST_RANGE;
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Each find starts from a clean node memory.
      S_CLEAR: begin
        node_wr = '{we: 1'b1, addr: clr_r, data: NODE_CLEAR};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_ROOT;
        end
      end

      S_ROOT: begin
        rec_w = NODE_CLEAR;
        rec_w.cost  = '0;
        rec_w.flags = 2'b01;
        rec_w.guess = estimate(start_r[COORD_W-1:0], start_r[CELL_W-1:COORD_W],
                               goal_x_r, goal_y_r);
        node_wr = '{we: 1'b1, addr: start_r, data: rec_w};
        open_head_nxt  = '{valid: 1'b1, idx: start_r};
        close_head_nxt = '0;
        open_cnt_nxt   = CNT_W'(1);
        close_cnt_nxt  = '0;
        best_nxt       = start_r;
        min_guess_nxt  = rec_w.guess;
        have_path_nxt  = 1'b1;
        state_nxt      = S_POP;
      end

      // Take the head of the open list.
      S_POP: begin
        if (!open_head_r.valid) begin
          res_nxt.status = ST_FAIL;
          state_nxt = S_FIN;
        end else begin
          node_raddr = open_head_r.idx;
          cur_nxt    = open_head_r.idx;
          state_nxt  = S_POP_D;
        end
      end

      // Move it onto the closed stack.
      S_POP_D: begin
        rec_w.next  = close_head_r;
        rec_w.prev  = '0;
        rec_w.flags = 2'b10;
        node_wr = '{we: 1'b1, addr: cur_r, data: rec_w};
        tmp_a_nxt = node_rdata.next.valid ? node_rdata.next : '0;
        tmp_b_nxt = close_head_r;
        open_head_nxt  = node_rdata.next.valid ? node_rdata.next : '0;
        close_head_nxt = cur_link;
        if (open_cnt_r != '0) begin
          open_cnt_nxt = open_cnt_r - 1'b1;
        end
        close_cnt_nxt = close_cnt_r + 1'b1;
        cur_cost_nxt  = node_rdata.cost;
        if (node_rdata.guess < min_guess_r) begin
          min_guess_nxt = node_rdata.guess;
          best_nxt      = cur_r;
        end
        state_nxt = S_POP_P1;
      end

      S_POP_P1: begin
        if (tmp_a_r.valid) begin
          patch_addr_nxt = tmp_a_r.idx; patch_next_nxt = 1'b0;
          patch_val_nxt = '0;           ret_nxt = S_POP_P2;
          state_nxt = S_PATCH_RD;
        end else begin
          state_nxt = S_POP_P2;
        end
      end

      S_POP_P2: begin
        if (tmp_b_r.valid) begin
          patch_addr_nxt = tmp_b_r.idx; patch_next_nxt = 1'b0;
          patch_val_nxt = cur_link;     ret_nxt = S_GOAL;
          state_nxt = S_PATCH_RD;
        end else begin
          state_nxt = S_GOAL;
        end
      end

      S_GOAL: begin
        if (cur_r == {goal_y_r, goal_x_r}) begin
          best_nxt = cur_r;
          res_nxt.status = ST_DONE;
          state_nxt = S_FIN;
        end else begin
          dir_nxt = '0;
          all_fail_nxt = 1'b1;
          state_nxt = S_DIR;
        end
      end

      // Fetch the neighbor in the current direction if enabled and on the map.
      S_DIR: begin
        if (cfg.dir_mask[dir_r] && nb_in_map) begin
          nb_nxt     = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
          node_raddr = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
          pass_raddr = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
          state_nxt  = S_NB;
        end else begin
          state_nxt = S_NEXTDIR;
        end
      end

      S_NB: begin
        if (!pass_rdata || (cand >= {1'b0, node_rdata.cost})) begin
          state_nxt = S_NEXTDIR;
        end else begin
          all_fail_nxt = 1'b0;
          rec_w.cost   = cand[COST_W-1:0];
          rec_w.parent = cur_link;
          tmp_a_nxt    = node_rdata.next;
          tmp_b_nxt    = node_rdata.prev;
          ul_close_nxt = !node_rdata.flags[0];
          if (node_rdata.flags[0] || node_rdata.flags[1]) begin
            state_nxt = S_UL1;
          end else begin
            rec_w.guess = estimate(nb_r[COORD_W-1:0], nb_r[CELL_W-1:COORD_W],
                                   goal_x_r, goal_y_r);
            state_nxt = S_INS;
          end
          nb_rec_nxt = rec_w;
        end
      end

      // Unlink the neighbor from whichever list holds it.
      S_UL1: begin
        if (tmp_a_r.valid) begin
          patch_addr_nxt = tmp_a_r.idx; patch_next_nxt = 1'b0;
          patch_val_nxt = tmp_b_r;      ret_nxt = S_UL2;
          state_nxt = S_PATCH_RD;
        end else begin
          state_nxt = S_UL2;
        end
      end

      S_UL2: begin
        if (ul_close_r) begin
          if (close_cnt_r != '0) begin
            close_cnt_nxt = close_cnt_r - 1'b1;
          end
        end else if (open_cnt_r != '0) begin
          open_cnt_nxt = open_cnt_r - 1'b1;
        end
        if (tmp_b_r.valid) begin
          patch_addr_nxt = tmp_b_r.idx; patch_next_nxt = 1'b1;
          patch_val_nxt = tmp_a_r;      ret_nxt = S_INS;
          state_nxt = S_PATCH_RD;
        end else begin
          if (ul_close_r) begin
            close_head_nxt = tmp_a_r;
          end else begin
            open_head_nxt = tmp_a_r;
          end
          state_nxt = S_INS;
        end
      end

      // Sorted insert: walk the open list to the first sum not below ours.
      S_INS: begin
        f_nxt      = {1'b0, nb_rec_r.cost} + {2'b00, nb_rec_r.guess};
        walk_p_nxt = open_head_r;
        walk_b_nxt = '0;
        state_nxt  = S_WALK;
      end

      S_WALK: begin
        if (walk_p_r.valid) begin
          node_raddr = walk_p_r.idx;
          state_nxt  = S_WALK_D;
        end else begin
          state_nxt = S_LINK;
        end
      end

      S_WALK_D: begin
        if (f_r <= rd_sum) begin
          state_nxt = S_LINK;
        end else begin
          walk_b_nxt = walk_p_r;
          walk_p_nxt = node_rdata.next;
          state_nxt  = S_WALK;
        end
      end

      S_LINK: begin
        rec_w = nb_rec_r;
        rec_w.flags = 2'b01;
        rec_w.next  = walk_p_r.valid ? walk_p_r : '0;
        rec_w.prev  = walk_b_r;
        node_wr = '{we: 1'b1, addr: nb_r, data: rec_w};
        open_cnt_nxt = open_cnt_r + 1'b1;
        state_nxt = S_LINK_B;
      end

      S_LINK_B: begin
        if (walk_b_r.valid) begin
          patch_addr_nxt = walk_b_r.idx; patch_next_nxt = 1'b1;
          patch_val_nxt = nb_link;       ret_nxt = S_LINK_P;
          state_nxt = S_PATCH_RD;
        end else begin
          open_head_nxt = nb_link;
          state_nxt = S_LINK_P;
        end
      end

      S_LINK_P: begin
        if (walk_p_r.valid) begin
          patch_addr_nxt = walk_p_r.idx; patch_next_nxt = 1'b0;
          patch_val_nxt = nb_link;       ret_nxt = S_NEXTDIR;
          state_nxt = S_PATCH_RD;
        end else begin
          state_nxt = S_NEXTDIR;
        end
      end

      S_NEXTDIR: begin
        if (dir_r == 3'd7) begin
          state_nxt = S_AFTER;
        end else begin
          dir_nxt = dir_r + 1'b1;
          state_nxt = S_DIR;
        end
      end

      // A dead end drops the top of the closed stack.
      S_AFTER: begin
        if (all_fail_r && close_head_r.valid) begin
          node_raddr = close_head_r.idx;
          state_nxt  = S_CPOP;
        end else begin
          state_nxt = S_LIM;
        end
      end

      S_CPOP: begin
        rec_w.flags = {1'b0, node_rdata.flags[0]};
        node_wr = '{we: 1'b1, addr: close_head_r.idx, data: rec_w};
        close_head_nxt = node_rdata.next.valid ? node_rdata.next : '0;
        tmp_a_nxt      = node_rdata.next.valid ? node_rdata.next : '0;
        if (close_cnt_r != '0) begin
          close_cnt_nxt = close_cnt_r - 1'b1;
        end
        state_nxt = S_CPOP_P;
      end

      S_CPOP_P: begin
        if (tmp_a_r.valid) begin
          patch_addr_nxt = tmp_a_r.idx; patch_next_nxt = 1'b0;
          patch_val_nxt = '0;           ret_nxt = S_LIM;
          state_nxt = S_PATCH_RD;
        end else begin
          state_nxt = S_LIM;
        end
      end

      S_LIM: begin
        if ((open_cnt_r >= cfg.open_limit) || (close_cnt_r >= cfg.close_limit)) begin
          res_nxt.status = ST_LIMIT;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_POP;
        end
      end

      // Report the best point and its cost.
      S_FIN: begin
        node_raddr = best_r;
        state_nxt  = S_FIN_D;
      end

      S_FIN_D: begin
        res_nxt.reach_x   = best_r[COORD_W-1:0];
        res_nxt.reach_y   = best_r[CELL_W-1:COORD_W];
        res_nxt.path_cost = node_rdata.cost;
        res_nxt.step_x    = '0;
        res_nxt.step_y    = '0;
        state_nxt = S_DONE;
      end

      // Path read back: follow parents until the cost drops to the index.
      S_RD_BEST: begin
        res_nxt.status    = ST_RANGE;
        res_nxt.reach_x   = best_r[COORD_W-1:0];
        res_nxt.reach_y   = best_r[CELL_W-1:COORD_W];
        res_nxt.path_cost = node_rdata.cost;
        if (si_r <= node_rdata.cost) begin
          walk_p_nxt = '{valid: 1'b1, idx: best_r};
          state_nxt  = S_TRACE;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_TRACE: begin
        if (walk_p_r.valid) begin
          node_raddr = walk_p_r.idx;
          state_nxt  = S_TRACE_D;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_TRACE_D: begin
        if (node_rdata.cost <= si_r) begin
          res_nxt.status = ST_DONE;
          res_nxt.step_x = walk_p_r.idx[COORD_W-1:0];
          res_nxt.step_y = walk_p_r.idx[CELL_W-1:COORD_W];
          state_nxt = S_DONE;
        end else begin
          walk_p_nxt = node_rdata.parent;
          state_nxt  = S_TRACE;
        end
      end

      // Read-modify-write of one link field of another node.
      S_PATCH_RD: begin
        node_raddr = patch_addr_r;
        state_nxt  = S_PATCH_WR;
      end

      S_PATCH_WR: begin
        if (patch_next_r) begin
          rec_w.next = patch_val_r;
        end else begin
          rec_w.prev = patch_val_r;
        end
        node_wr = '{we: 1'b1, addr: patch_addr_r, data: rec_w};
        state_nxt = ret_r;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_BOOT;
      clr_r         <= '0;
      have_path_r   <= 1'b0;
      best_r        <= '0;
      open_head_r   <= '0;
      close_head_r  <= '0;
      open_cnt_r    <= '0;
      close_cnt_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      have_path_r   <= have_path_nxt;
      best_r        <= best_nxt;
      open_head_r   <= open_head_nxt;
      close_head_r  <= close_head_nxt;
      open_cnt_r    <= open_cnt_nxt;
      close_cnt_r   <= close_cnt_nxt;
      ret_r         <= ret_nxt;
      goal_x_r      <= goal_x_nxt;
      goal_y_r      <= goal_y_nxt;
      start_r       <= start_nxt;
      si_r          <= si_nxt;
      min_guess_r   <= min_guess_nxt;
      cur_r         <= cur_nxt;
      cur_cost_r    <= cur_cost_nxt;
      dir_r         <= dir_nxt;
      all_fail_r    <= all_fail_nxt;
      nb_r          <= nb_nxt;
      nb_rec_r      <= nb_rec_nxt;
      tmp_a_r       <= tmp_a_nxt;
      tmp_b_r       <= tmp_b_nxt;
      ul_close_r    <= ul_close_nxt;
      walk_p_r      <= walk_p_nxt;
      walk_b_r      <= walk_b_nxt;
      f_r           <= f_nxt;
      patch_addr_r  <= patch_addr_nxt;
      patch_next_r  <= patch_next_nxt;
      patch_val_r   <= patch_val_nxt;
      res_r         <= res_nxt;
    end
  end

endmodule

// ===== hdl/grid_astar_path_search.sv =====
// Top level of the grid path search: channels, configuration registers and memories.
//
// Usage: load passability bits with write commands (opcode 0), then issue a
// find (opcode 1) with start and target cells; path nodes are read back by
// cost index with opcode 2. Every accepted command on the in_ channel yields
// exactly one result transfer on the out_ channel.
// A find first clears the 4096-entry node memory, then expands one node at a
// time, sorting each updated neighbor into the open list by walking it entry
// by entry. All steps share the single node memory port.
// One command is worked on at a time; in_ready is high while the sequencer
// is idle, which it is again once its result is taken. A finished result
// sits in the output register, so the next command may be taken while it
// waits; a further result waits in the sequencer until the receiver takes
// the one held.
// Reset: a pass over all 4096 cells marks every cell blocked and unreached; no
// command is accepted during it, while configuration writes are taken as always.
module grid_astar_path_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_opcode,
  input  logic [gap_pkg::COORD_W-1:0]       in_cell_x,
  input  logic [gap_pkg::COORD_W-1:0]       in_cell_y,
  input  logic [gap_pkg::COORD_W-1:0]       in_goal_x,
  input  logic [gap_pkg::COORD_W-1:0]       in_goal_y,
  input  logic                              in_passable,
  input  logic [gap_pkg::COST_W-1:0]        in_step_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [gap_pkg::COORD_W-1:0]       out_reach_x,
  output logic [gap_pkg::COORD_W-1:0]       out_reach_y,
  output logic [gap_pkg::COST_W-1:0]        out_path_cost,
  output logic [gap_pkg::COORD_W-1:0]       out_step_x,
  output logic [gap_pkg::COORD_W-1:0]       out_step_y,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gap_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gap_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gap_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import gap_pkg::*;

  cfg_t      cfg_r;
  logic      cfg_we;
  logic [2:0] reg_sel;
  cmd_t      cmd;
  logic      cmd_ready;
  logic      res_valid;
  logic      res_ready;
  res_t      res;
  res_t      out_r;
  logic      out_valid_r;
  node_wr_t  node_wr;
  logic [CELL_W-1:0] node_raddr;
  node_t     node_rdata;
  logic [NODE_W-1:0] node_rdata_raw;
  pass_wr_t  pass_wr;
  logic [CELL_W-1:0] pass_raddr;
  logic      pass_rdata;

  // Configuration register file.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dir_mask    <= RST_DIR_MASK;
      cfg_r.open_limit  <= RST_OPEN_LIMIT;
      cfg_r.close_limit <= RST_CLOSE_LIMIT;
      cfg_r.map_width   <= RST_MAP_DIM;
      cfg_r.map_height  <= RST_MAP_DIM;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_DIR_MASK:    cfg_r.dir_mask    <= pwdata[MASK_W-1:0];
        REG_OPEN_LIMIT:  cfg_r.open_limit  <= pwdata[CNT_W-1:0];
        REG_CLOSE_LIMIT: cfg_r.close_limit <= pwdata[CNT_W-1:0];
        REG_MAP_WIDTH:   cfg_r.map_width   <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT:  cfg_r.map_height  <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_DIR_MASK:    prdata = {{(CFG_DATA_W-MASK_W){1'b0}}, cfg_r.dir_mask};
      REG_OPEN_LIMIT:  prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg_r.open_limit};
      REG_CLOSE_LIMIT: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg_r.close_limit};
      REG_MAP_WIDTH:   prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, cfg_r.map_width};
      REG_MAP_HEIGHT:  prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, cfg_r.map_height};
      default:         prdata = '0;
    endcase
  end

  // Command transfer into the sequencer.
  assign cmd = '{opcode: in_opcode, cell_x: in_cell_x, cell_y: in_cell_y,
                 goal_x: in_goal_x, goal_y: in_goal_y, passable: in_passable,
                 step_index: in_step_index};
  assign in_ready = cmd_ready;

  gap_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (in_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .node_wr    (node_wr),
    .node_raddr (node_raddr),
    .node_rdata (node_rdata),
    .pass_wr    (pass_wr),
    .pass_raddr (pass_raddr),
    .pass_rdata (pass_rdata)
  );

  // Node records: cost, list flags, guess, parent and list links.
  gap_ram #(.WIDTH(NODE_W), .DEPTH(CELL_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_wr.we),
    .waddr (node_wr.addr),
    .wdata (node_wr.data),
    .raddr (node_raddr),
    .rdata (node_rdata_raw)
  );
  assign node_rdata = node_t'(node_rdata_raw);

  // Passability bits.
  gap_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_pass_ram (
    .clk   (clk),
    .we    (pass_wr.we),
    .waddr (pass_wr.addr),
    .wdata (pass_wr.data),
    .raddr (pass_raddr),
    .rdata (pass_rdata)
  );

  // Output register parts the sequencer from the receiver.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_reach_x   = out_r.reach_x;
  assign out_reach_y   = out_r.reach_y;
  assign out_path_cost = out_r.path_cost;
  assign out_step_x    = out_r.step_x;
  assign out_step_y    = out_r.step_y;

  // A result handed over always shows up on the output next cycle.
  a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid)
    else $error("result transfer lost before the output register");

  // The sequencer never takes a command while it still holds a result.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_ready && res_valid))
    else $error("command accepted while a result is pending");

  // An out-of-range status never carries a path node.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_RANGE)) |-> ((out_step_x == '0) && (out_step_y == '0)))
    else $error("path node reported with out-of-range status");

endmodule
